// ===== sv/tab_space_convert_stream_top_defines.svh =====
// assertion macros for the tab/space converter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TAB_SPACE_CONVERT_STREAM_TOP_DEFINES_SVH
`define TAB_SPACE_CONVERT_STREAM_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tab space converter check failed");

// condition that must never hold outside reset
`define TSC_NEVER(lbl, clk, rst_n, cond) \
	`TSC_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== sv/tsc_pkg.sv =====
// shared types and constants for the tab/space converter
// no dependencies
`default_nettype none
package tsc_pkg;

	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam int unsigned DEFAULT_STOP = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 6;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE         = 2'd0,
		CFG_FIRST_STOP   = 2'd1,
		CFG_STOP_SPACING = 2'd2
	} cfg_idx_t;

	// one result item as it leaves the block
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/tsc_queue.sv =====
// small register queue between the front and back parts
// depends on nothing but its parameters
`default_nettype none
module tsc_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  not_empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/tsc_front.sv =====
// front part: config registers, column tracking and item classification
// depends on tsc_pkg
`default_nettype none
module tsc_front
	import tsc_pkg::*;
#(
	parameter int unsigned MAX_STOP_SPAN = 32,
	parameter int unsigned DW = $clog2(MAX_STOP_SPAN + 1),
	parameter int unsigned CMD_W = 2 * DW + 9
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_en,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  end_of_text,
	output logic                       cmd_push,
	output logic      [CMD_W-1:0]      cmd_data
);
	localparam int unsigned SW = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;

	// pre: spaces flushed first; then cnt copies of out_b
	typedef struct packed {
		logic [DW-1:0] pre;
		logic [7:0]    out_b;
		logic          has;
		logic [DW-1:0] cnt;
	} cmd_t;

	logic                  mode_q;
	logic [CFG_DATA_W-1:0] first_stop_q, stop_spacing_q;
	logic [DW-1:0]         dist_q, pend_q;
	logic                  line_start_q;

	logic [SW-1:0] fs_ext, sp_ext, max_ext;
	logic [DW-1:0] spacing, first_dist, dist_now, dist_dec, dist_adv;
	logic          hit;
	logic [DW-1:0] dist_d, pend_d;
	logic          line_start_d;
	cmd_t          cmd;
	logic          push_d;

	assign fs_ext  = SW'(first_stop_q);
	assign sp_ext  = SW'(stop_spacing_q);
	assign max_ext = SW'(MAX_STOP_SPAN);

	always_comb begin
		if (sp_ext == '0) begin
			spacing = DW'(1);
		end else if (sp_ext > max_ext) begin
			spacing = DW'(MAX_STOP_SPAN);
		end else begin
			spacing = sp_ext[DW-1:0];
		end
		if (fs_ext == '0) begin
			first_dist = spacing;
		end else if (fs_ext > max_ext) begin
			first_dist = DW'(MAX_STOP_SPAN);
		end else begin
			first_dist = fs_ext[DW-1:0];
		end
	end

	// at line start the distance comes fresh from the registers
	assign dist_now = line_start_q ? first_dist : dist_q;
	assign dist_dec = dist_now - DW'(1);
	assign hit      = (dist_dec == '0);
	assign dist_adv = hit ? spacing : dist_dec;

	always_comb begin
		dist_d       = dist_q;
		pend_d       = pend_q;
		line_start_d = line_start_q;
		push_d       = 1'b1;
		cmd.pre      = pend_q;
		cmd.out_b    = in_byte;
		cmd.has      = 1'b1;
		cmd.cnt      = DW'(1);
		if (end_of_text) begin
			cmd.out_b    = 8'd0;
			cmd.has      = 1'b0;
			pend_d       = '0;
			line_start_d = 1'b1;
		end else if (mode_q && in_byte == CH_SP) begin
			dist_d       = dist_adv;
			line_start_d = 1'b0;
			cmd.pre      = '0;
			cmd.out_b    = CH_TAB;
			if (hit) begin
				pend_d = '0;
			end else begin
				pend_d = pend_q + DW'(1);
				push_d = 1'b0;
			end
		end else if (in_byte == CH_TAB) begin
			pend_d       = '0;
			dist_d       = spacing;
			line_start_d = 1'b0;
			if (!mode_q) begin
				cmd.out_b = CH_SP;
				cmd.cnt   = dist_now;
			end
		end else begin
			pend_d = '0;
			if (in_byte == CH_NL) begin
				line_start_d = 1'b1;
			end else begin
				dist_d       = dist_adv;
				line_start_d = 1'b0;
			end
		end
	end

	assign cmd_push = item_en && push_d;
	assign cmd_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			first_stop_q   <= CFG_DATA_W'(DEFAULT_STOP);
			stop_spacing_q <= CFG_DATA_W'(DEFAULT_STOP);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:         mode_q         <= cfg_data[0];
				CFG_FIRST_STOP:   first_stop_q   <= cfg_data;
				CFG_STOP_SPACING: stop_spacing_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q       <= DW'(DEFAULT_STOP);
			pend_q       <= '0;
			line_start_q <= 1'b1;
		end else if (item_en) begin
			dist_q       <= dist_d;
			pend_q       <= pend_d;
			line_start_q <= line_start_d;
		end
	end
endmodule
`default_nettype wire

// ===== sv/tsc_back.sv =====
// back part: plays out queued commands one result per cycle while the receiver keeps popping
// depends on tsc_pkg and the assertion macro header
`default_nettype none
`include "tab_space_convert_stream_top_defines.svh"
module tsc_back
	import tsc_pkg::*;
#(
	parameter int unsigned MAX_STOP_SPAN = 32,
	parameter int unsigned DW = $clog2(MAX_STOP_SPAN + 1),
	parameter int unsigned CMD_W = 2 * DW + 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_avail,
	input  wire logic [CMD_W-1:0] cmd_data,
	output logic                  cmd_pop,
	input  wire logic             pop,
	output logic                  empty,
	output res_t                  res
);
	typedef struct packed {
		logic [DW-1:0] pre;
		logic [7:0]    out_b;
		logic          has;
		logic [DW-1:0] cnt;
	} cmd_t;

	cmd_t work_q;
	logic work_valid_q;
	res_t out_q;
	logic out_valid_q;

	logic in_pre, out_free, step, final_step, load;
	res_t next_res;

	assign in_pre   = (work_q.pre != '0);
	assign out_free = !out_valid_q || pop;
	assign step     = work_valid_q && out_free;

	always_comb begin
		next_res.out_byte = in_pre ? CH_SP : work_q.out_b;
		next_res.has_byte = in_pre ? 1'b1 : work_q.has;
		next_res.last     = !in_pre && (work_q.cnt == DW'(1));
	end

	assign final_step = step && next_res.last;
	// next command is picked up in the cycle the previous one finishes
	assign load       = cmd_avail && (!work_valid_q || final_step);
	assign cmd_pop    = load;

	always_ff @(posedge clk) begin
		if (load) begin
			work_q <= cmd_t'(cmd_data);
		end else if (step) begin
			if (in_pre) begin
				work_q.pre <= work_q.pre - DW'(1);
			end else begin
				work_q.cnt <= work_q.cnt - DW'(1);
			end
		end
		if (step) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				work_valid_q <= 1'b1;
			end else if (final_step) begin
				work_valid_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign res   = out_q;

	// a bare end result always closes its item
	`TSC_ASSERT(a_end_is_last, clk, arst_n, (out_valid_q && !out_q.has_byte) |-> out_q.last)
	// a live command never runs with an exhausted main count
	`TSC_NEVER(a_cnt_live, clk, arst_n, work_valid_q && work_q.cnt == '0)
	// flushed spaces never end an item
	`TSC_ASSERT(a_pre_not_last, clk, arst_n, (step && in_pre) |=> !out_q.last)
endmodule
`default_nettype wire

// ===== sv/tab_space_convert_stream_top.sv =====
// top level of the tab/space converter stream block
// depends on tsc_pkg, tsc_queue, tsc_front and tsc_back
`default_nettype none
// path: an accepted item passes the command queue, then the back part's work and output registers
// throughput: one result per cycle from the back part while the receiver keeps popping; the
// back part's single output step limits the rate, and a four-deep command queue absorbs bursts
// items that make no result (held spaces) never reach the queue
// reset: arst_n clears queue, column state and output; registers return to mode 0, stops 8
module tab_space_convert_stream_top
	import tsc_pkg::*;
#(
	parameter int unsigned MAX_STOP_SPAN = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input item side
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  end_of_text,
	// result side
	output logic                       empty,
	input  wire logic                  pop,
	output logic      [7:0]            out_byte,
	output logic                       has_byte,
	output logic                       last
);
	// distance and counts hold values up to the stop span itself
	localparam int unsigned DW    = $clog2(MAX_STOP_SPAN + 1);
	localparam int unsigned CMD_W = 2 * DW + 9;

	logic             item_en;
	logic             cmd_push, cmd_pop, cmd_avail, queue_full;
	logic [CMD_W-1:0] cmd_wr, cmd_rd;
	res_t             res;

	// config is always taken; writes should only land while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	// input stalls only when the command queue is full
	assign full    = queue_full;
	assign item_en = push && !queue_full;

	tsc_front #(
		.MAX_STOP_SPAN(MAX_STOP_SPAN),
		.DW           (DW),
		.CMD_W        (CMD_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_en    (item_en),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_wr)
	);

	tsc_queue #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (cmd_wr),
		.rd_en    (cmd_pop),
		.rd_data  (cmd_rd),
		.full     (queue_full),
		.not_empty(cmd_avail)
	);

	tsc_back #(
		.MAX_STOP_SPAN(MAX_STOP_SPAN),
		.DW           (DW),
		.CMD_W        (CMD_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_avail(cmd_avail),
		.cmd_data (cmd_rd),
		.cmd_pop  (cmd_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign out_byte = res.out_byte;
	assign has_byte = res.has_byte;
	assign last     = res.last;
endmodule
`default_nettype wire

// ===== bench/tab_space_convert_stream_top_test.sv =====
// self-checking bench for tab_space_convert_stream_top: expand and compress modes, stops
// depends on tsc_pkg and the converter rtl; predicts every result item from its own state
module tab_space_convert_stream_top_test;
	import tsc_pkg::*;

	localparam int unsigned CLK_PERIOD     = 8;
	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned MAX_STOP_SPAN  = 32;
	// cycles to let an item with no result finish before touching registers
	localparam int unsigned SETTLE_CYCLES  = 6;
	localparam int unsigned PRESSURE_HOLD  = 300;
	localparam int unsigned TIMEOUT_CYCLES = 5_000_000;
	// index 3 is not a register; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	logic                  full;
	logic [7:0]            in_byte;
	logic                  end_of_text;
	logic                  empty;
	logic                  pop;
	logic [7:0]            out_byte;
	logic                  has_byte;
	logic                  last;

	tab_space_convert_stream_top #(
		.MAX_STOP_SPAN(MAX_STOP_SPAN)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.last       (last)
	);

	// converter state as the bench sees it
	logic       conv_mode;
	logic [5:0] conv_first_stop;
	logic [5:0] conv_spacing;
	logic [5:0] stop_dist;
	logic [5:0] held_spaces;
	logic       line_start;

	res_t expected_results[$];
	res_t step_results[$];

	int unsigned mismatch_count;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned cfg_writes;

	// knobs for the two sides
	logic        src_idling;
	logic        sink_idling;
	logic        sink_held;
	int unsigned hold_req;
	int unsigned sink_gap;

	initial begin
		clk = 1'b0;
	end

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// column and stop tracking
	// ---------------------------------------------------------------

	// spacing with zero lifted to one and large values clipped
	function automatic logic [5:0] spacing_eff();
		logic [5:0] s;
		s = conv_spacing;
		if (s == 6'd0)
			s = 6'd1;
		if (s > MAX_STOP_SPAN)
			s = 6'(MAX_STOP_SPAN);
		return s;
	endfunction

	// distance to next stop; recomputed from registers on an empty line
	function automatic logic [5:0] distance_eff();
		logic [5:0] f;
		if (!line_start)
			return stop_dist;
		f = conv_first_stop;
		if (f > MAX_STOP_SPAN)
			f = 6'(MAX_STOP_SPAN);
		return (f == 6'd0) ? spacing_eff() : f;
	endfunction

	// move one column right, report whether a stop was reached
	function automatic logic step_column();
		logic [5:0] d;
		logic       hit;
		d = distance_eff() - 6'd1;
		hit = (d == 6'd0);
		if (hit)
			d = spacing_eff();
		stop_dist = d;
		line_start = 1'b0;
		return hit;
	endfunction

	function automatic void start_line();
		line_start = 1'b1;
		stop_dist = distance_eff();
	endfunction

	function automatic void put_result(logic [7:0] b, logic h);
		res_t r;
		r.out_byte = b;
		r.has_byte = h;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void flush_held();
		while (held_spaces != 6'd0) begin
			put_result(CH_SP, 1'b1);
			held_spaces--;
		end
	endfunction

	function automatic void reset_converter_state();
		conv_mode = 1'b0;
		conv_first_stop = 6'(DEFAULT_STOP);
		conv_spacing = 6'(DEFAULT_STOP);
		stop_dist = 6'(DEFAULT_STOP);
		held_spaces = 6'd0;
		line_start = 1'b1;
	endfunction

	// expected result items for one accepted input item
	function automatic void predict_conversion(logic [7:0] c, logic eot);
		logic [5:0] d;
		res_t       r;
		step_results.delete();
		if (eot) begin
			flush_held();
			put_result(8'd0, 1'b0);
			start_line();
		end else if (conv_mode && c == CH_SP) begin
			held_spaces++;
			if (step_column()) begin
				// run reached a stop: the whole run becomes one tab
				held_spaces = 6'd0;
				put_result(CH_TAB, 1'b1);
			end
		end else if (c == CH_TAB) begin
			flush_held();
			if (conv_mode) begin
				put_result(CH_TAB, 1'b1);
			end else begin
				d = distance_eff();
				repeat (d) put_result(CH_SP, 1'b1);
			end
			stop_dist = spacing_eff();
			line_start = 1'b0;
		end else begin
			flush_held();
			put_result(c, 1'b1);
			if (c == CH_NL)
				start_line();
			else
				void'(step_column());
		end
		if (step_results.size() != 0) begin
			r = step_results.pop_back();
			r.last = 1'b1;
			step_results.push_back(r);
		end
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// mostly back to back, some short pauses, rare long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 25);
	endfunction

	// offer one item and wait for the block to take it; push stays high afterwards
	task automatic send_item(input logic [7:0] b, input logic eot);
		int unsigned gap;
		gap = src_idling ? pick_gap() : 0;
		if (gap != 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push = 1'b1;
		in_byte = b;
		end_of_text = eot;
		do @(posedge clk); while (full);
		predict_conversion(b, eot);
		items_sent++;
	endtask

	// stop offering, wait for every expected item, then let held spaces settle
	task automatic drain_results();
		@(negedge clk);
		push = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; only called with the block idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MODE: begin
				conv_mode = data[0];
			end
			CFG_FIRST_STOP: begin
				conv_first_stop = data;
			end
			CFG_STOP_SPACING: begin
				conv_spacing = data;
			end
			default: begin
			end
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// text-like stream: space runs, tabs, newlines, printable bytes, some noise
	task automatic send_random_text(input int unsigned count);
		int unsigned sent;
		int unsigned r;
		int unsigned run_len;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 32) begin
				// occasional long run so compress mode reaches far stops
				run_len = (r < 3) ? $urandom_range(40, 12) : $urandom_range(9, 1);
				repeat (run_len) send_item(CH_SP, 1'b0);
				sent += run_len;
			end else begin
				if (r < 46)
					send_item(CH_TAB, 1'b0);
				else if (r < 56)
					send_item(CH_NL, 1'b0);
				else if (r < 86)
					send_item(8'($urandom_range(126, 33)), 1'b0);
				else if (r < 97)
					send_item(8'($urandom_range(255, 0)), 1'b0);
				else
					send_item(8'($urandom_range(255, 0)), 1'b1);
				sent++;
			end
		end
	endtask

	// stop register value: edges and saturation now and then, small stops mostly
	function automatic logic [5:0] pick_stop_value();
		int unsigned r;
		r = $urandom_range(9);
		case (r)
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'(MAX_STOP_SPAN);
			3: return 6'($urandom_range(63, MAX_STOP_SPAN + 1));
			default: return 6'($urandom_range(12, 2));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// receiver side
	// ---------------------------------------------------------------

	// long hold-off, counted here so the sender keeps offering meanwhile
	initial begin
		sink_held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				sink_held = 1'b1;
				repeat (hold_req) @(posedge clk);
				sink_held = 1'b0;
				hold_req = 0;
			end
		end
	end

	// pop driven at the falling edge
	always @(negedge clk) begin
		if (!arst_n || sink_held) begin
			pop = 1'b0;
		end else if (sink_gap != 0) begin
			pop = 1'b0;
			sink_gap--;
		end else begin
			pop = 1'b1;
			if (sink_idling)
				sink_gap = pick_gap();
		end
	end

	// compare each accepted result item with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected: out_byte %0d has_byte %0b last %0b",
					out_byte, has_byte, last);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (out_byte !== want.out_byte) begin
					$error("out_byte expected %0d actual %0d", want.out_byte, out_byte);
					mismatch_count++;
				end
				if (has_byte !== want.has_byte) begin
					$error("has_byte expected %0b actual %0b", want.has_byte, has_byte);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$error("last expected %0b actual %0b", want.last, last);
					mismatch_count++;
				end
			end
			results_checked++;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset registers: tab at line start, tab mid line, newline
	task automatic test_expand_defaults();
		send_item(CH_TAB, 1'b0);
		send_item("a", 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_NL, 1'b0);
		drain_results();
	endtask

	// clipped first stop, zero spacing, unused index, zero first stop, extreme bytes
	task automatic test_register_extremes();
		write_register(CFG_FIRST_STOP, 6'h3F);
		write_register(CFG_STOP_SPACING, 6'd0);
		write_register(CFG_UNUSED_IDX, 6'h3F);
		send_item(CH_TAB, 1'b0);
		send_item(CH_TAB, 1'b0);
		// end marker with every in_byte bit set, byte must be ignored
		send_item(8'hFF, 1'b1);
		drain_results();
		write_register(CFG_FIRST_STOP, 6'd0);
		write_register(CFG_STOP_SPACING, 6'h3F);
		send_item(CH_TAB, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		drain_results();
	endtask

	// space runs held, turned into a tab at a stop, flushed by text, tab, end
	task automatic test_compress_runs();
		write_register(CFG_MODE, 1'b1);
		write_register(CFG_FIRST_STOP, 6'd2);
		write_register(CFG_STOP_SPACING, 6'd3);
		send_item(CH_NL, 1'b0);
		send_item(CH_SP, 1'b0);
		send_item(CH_SP, 1'b0);
		send_item(CH_SP, 1'b0);
		send_item("x", 1'b0);
		send_item(CH_SP, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_SP, 1'b0);
		send_item(8'h00, 1'b1);
		drain_results();
	endtask

	// held space survives a switch to expand mode and is flushed before the tab
	task automatic test_mode_switch_flush();
		send_item(CH_SP, 1'b0);
		drain_results();
		write_register(CFG_MODE, 1'b0);
		send_item(CH_TAB, 1'b0);
		drain_results();
	endtask

	// receiver stalls for a long stretch while the sender keeps pushing
	task automatic test_backpressure();
		write_register(CFG_MODE, 1'b0);
		write_register(CFG_FIRST_STOP, 6'd4);
		write_register(CFG_STOP_SPACING, 6'd6);
		src_idling = 1'b0;
		@(negedge clk);
		hold_req = PRESSURE_HOLD;
		send_random_text(40);
		drain_results();
		src_idling = 1'b1;
	endtask

	// random registers per phase, written mid line too, random text in between
	task automatic test_random_text();
		for (int phase = 0; phase < 6; phase++) begin
			// some phases run with one or both sides never idling
			src_idling = (phase % 3) != 0;
			sink_idling = (phase % 2) != 0;
			write_register(CFG_MODE, 1'($urandom_range(1)));
			write_register(CFG_FIRST_STOP, pick_stop_value());
			write_register(CFG_STOP_SPACING, pick_stop_value());
			if ($urandom_range(3) == 0)
				write_register(CFG_UNUSED_IDX, 6'($urandom_range(63)));
			send_random_text(70);
			drain_results();
		end
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		push = 1'b0;
		in_byte = 8'd0;
		end_of_text = 1'b0;
		pop = 1'b0;
		sink_gap = 0;
		hold_req = 0;
		src_idling = 1'b1;
		sink_idling = 1'b1;
		mismatch_count = 0;
		items_sent = 0;
		results_checked = 0;
		cfg_writes = 0;
		reset_converter_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_expand_defaults();
		test_register_extremes();
		test_compress_runs();
		test_mode_switch_flush();
		test_backpressure();
		test_random_text();

		drain_results();
		$display("converted %0d items into %0d checked results, %0d register writes,",
			items_sent, results_checked, cfg_writes);
		$display("both modes, clipped and zero stops, held-space flushes and a long stall");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results still expected", expected_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
